>>> rtl/core/rtg_pkg.sv
package rtg_pkg;

	localparam int TempW    = 8;
	localparam int VoltW    = 9;
	localparam int CurrW    = 16;
	localparam int ModeW    = 4;
	localparam int ReqW     = 3;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int InDataW  = 40;
	localparam int OutDataW = 8;

	localparam logic [ReqW-1:0] REQ_TICK      = 3'd0;
	localparam logic [ReqW-1:0] REQ_ARM       = 3'd1;
	localparam logic [ReqW-1:0] REQ_DISARM    = 3'd2;
	localparam logic [ReqW-1:0] REQ_RELAY_OFF = 3'd3;
	localparam logic [ReqW-1:0] REQ_RELAY_ON  = 3'd4;

	localparam logic [ModeW-1:0] MODE_OFF     = 4'd0;
	localparam logic [ModeW-1:0] MODE_HEAT    = 4'd1;
	localparam logic [ModeW-1:0] MODE_COOL    = 4'd2;
	localparam logic [ModeW-1:0] MODE_IN      = 4'd3;
	localparam logic [ModeW-1:0] MODE_OUT     = 4'd4;
	localparam logic [ModeW-1:0] MODE_W_HEAT  = 4'd5;
	localparam logic [ModeW-1:0] MODE_W_COOL  = 4'd6;
	localparam logic [ModeW-1:0] MODE_W_IN    = 4'd7;
	localparam logic [ModeW-1:0] MODE_W_OUT   = 4'd8;
	localparam logic [ModeW-1:0] MODE_FILL    = 4'd9;
	localparam logic [ModeW-1:0] MODE_DRAIN   = 4'd10;

	localparam logic [1:0] LEAK_S1     = 2'd0;
	localparam logic [1:0] LEAK_S2     = 2'd1;
	localparam logic [1:0] LEAK_EITHER = 2'd2;
	localparam logic [1:0] LEAK_BOTH   = 2'd3;

	localparam logic [1:0] BASE_HEAT = 2'd0;
	localparam logic [1:0] BASE_COOL = 2'd1;
	localparam logic [1:0] BASE_IN   = 2'd2;
	localparam logic [1:0] BASE_OUT  = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_MODE       = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_LEAK_SRC   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LEVEL_SEL  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TEMP_LOW   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TEMP_HIGH  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_VOLT_LOW   = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_VOLT_HIGH  = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_CURR_LIMIT = 3'd7;

	typedef struct packed {
		logic drv;
		logic val;
	} relay_act_t;

endpackage

>>> rtl/core/relay_thermostat_leak_guard.sv
// Channel  Direction  Payload (lowest bit first)
// s_axis   in         tuser: req_type; tdata: temperature, sensor1_level,
//                     sensor2_level, voltage, current_ma, link_ready
// m_axis   out        tdata: relay_on, relay_reported, guard_cleared, guard_armed
// cfg      in         cfg_wen, cfg_index, cfg_data
//
// One beat is taken per clock while the output register is empty or m_axis_tready is high;
// its result is registered in the output register.
// The relay and guard state update in the same edge that accepts the beat.
// A stalled output holds its beat and blocks input only while it is full.
// Reset clears the relay, the guard, the output valid and the configuration to zero.
module relay_thermostat_leak_guard (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// temperature, sensor1_level, sensor2_level, voltage, current_ma, link_ready
	input  logic [rtg_pkg::InDataW-1:0]         s_axis_tdata,
	// req_type
	input  logic [rtg_pkg::ReqW-1:0]            s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// relay_on, relay_reported, guard_cleared, guard_armed
	output logic [rtg_pkg::OutDataW-1:0]        m_axis_tdata,
	input  logic                                cfg_wen,
	input  logic [rtg_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [rtg_pkg::CfgDataW-1:0]        cfg_data
);

	logic [rtg_pkg::ModeW-1:0]         mode_q;
	logic [1:0]                        leak_src_q;
	logic [1:0]                        level_sel_q;
	logic signed [rtg_pkg::TempW-1:0]  temp_low_q;
	logic signed [rtg_pkg::TempW-1:0]  temp_high_q;
	logic [rtg_pkg::VoltW-1:0]         volt_low_q;
	logic [rtg_pkg::VoltW-1:0]         volt_high_q;
	logic [rtg_pkg::CurrW-1:0]         curr_limit_q;

	logic relay_q, guard_q;
	logic out_valid_q;
	logic [3:0] out_data_q;

	logic signed [rtg_pkg::TempW-1:0] temp;
	logic w1, w2, link, wet, low_wet, high_dry;
	logic [rtg_pkg::VoltW-1:0] volt;
	logic [rtg_pkg::CurrW-1:0] curr;
	logic [rtg_pkg::ModeW-1:0] base_code;
	rtg_pkg::relay_act_t base_act;
	logic relay_n, guard_n, rep_n, clr_n;
	logic in_accept;

	function automatic rtg_pkg::relay_act_t base_eval(
		input logic [1:0]                       sel,
		input logic signed [rtg_pkg::TempW-1:0] t,
		input logic signed [rtg_pkg::TempW-1:0] lo,
		input logic signed [rtg_pkg::TempW-1:0] hi
	);
		rtg_pkg::relay_act_t act;
		logic in_win;
		in_win = (lo <= t) && (t <= hi);
		act = '0;
		unique case (sel)
			rtg_pkg::BASE_HEAT: begin
				if (t >= hi) begin
					act = '{drv: 1'b1, val: 1'b0};
				end else if (t < lo) begin
					act = '{drv: 1'b1, val: 1'b1};
				end
			end
			rtg_pkg::BASE_COOL: begin
				if (t <= lo) begin
					act = '{drv: 1'b1, val: 1'b0};
				end else if (t >= hi) begin
					act = '{drv: 1'b1, val: 1'b1};
				end
			end
			rtg_pkg::BASE_IN:  act = '{drv: 1'b1, val: in_win};
			rtg_pkg::BASE_OUT: act = '{drv: 1'b1, val: !in_win};
			default: act = '0;
		endcase
		return act;
	endfunction

	assign temp = s_axis_tdata[7:0];
	assign w1   = !s_axis_tdata[8];
	assign w2   = !s_axis_tdata[9];
	assign volt = s_axis_tdata[18:10];
	assign curr = s_axis_tdata[34:19];
	assign link = s_axis_tdata[35];

	always_comb begin
		unique case (leak_src_q)
			rtg_pkg::LEAK_S1:     wet = w1;
			rtg_pkg::LEAK_S2:     wet = w2;
			rtg_pkg::LEAK_EITHER: wet = w1 || w2;
			default:              wet = w1 && w2;
		endcase
	end

	assign low_wet  = level_sel_q[0] ? w2 : w1;
	assign high_dry = level_sel_q[1] ? !w2 : !w1;

	// Gated modes reuse the base evaluation with the code shifted down by four.
	assign base_code = (mode_q >= rtg_pkg::MODE_W_HEAT) ? mode_q - rtg_pkg::MODE_W_HEAT
	                                                    : mode_q - rtg_pkg::MODE_HEAT;
	assign base_act  = base_eval(base_code[1:0], temp, temp_low_q, temp_high_q);

	always_comb begin
		relay_n = relay_q;
		guard_n = guard_q;
		rep_n   = 1'b0;
		clr_n   = 1'b0;
		unique case (s_axis_tuser)
			rtg_pkg::REQ_ARM:       guard_n = 1'b1;
			rtg_pkg::REQ_DISARM:    guard_n = 1'b0;
			rtg_pkg::REQ_RELAY_OFF: relay_n = 1'b0;
			rtg_pkg::REQ_RELAY_ON:  relay_n = 1'b1;
			rtg_pkg::REQ_TICK: begin
				if (link) begin
					if (volt != '0) begin
						if (volt >= volt_high_q || volt <= volt_low_q || curr >= curr_limit_q) begin
							relay_n = 1'b0;
							rep_n   = 1'b1;
						end
					end
					if (guard_q && wet) begin
						relay_n = 1'b0;
						rep_n   = 1'b1;
					end
					case (mode_q) inside
						[rtg_pkg::MODE_W_HEAT:rtg_pkg::MODE_DRAIN]: begin
							if (guard_q) begin
								guard_n = 1'b0;
								clr_n   = 1'b1;
							end
						end
						default: ;
					endcase
					case (mode_q) inside
						[rtg_pkg::MODE_HEAT:rtg_pkg::MODE_OUT]: begin
							if (base_act.drv) begin
								relay_n = base_act.val;
								rep_n   = 1'b1;
							end
						end
						[rtg_pkg::MODE_W_HEAT:rtg_pkg::MODE_W_OUT]: begin
							if (wet && base_act.drv) begin
								relay_n = base_act.val;
								rep_n   = 1'b1;
							end
						end
						rtg_pkg::MODE_FILL: begin
							if (low_wet) begin
								relay_n = high_dry;
								rep_n   = 1'b1;
							end
						end
						rtg_pkg::MODE_DRAIN: begin
							if (low_wet) begin
								relay_n = !high_dry;
								rep_n   = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			leak_src_q   <= '0;
			level_sel_q  <= '0;
			temp_low_q   <= '0;
			temp_high_q  <= '0;
			volt_low_q   <= '0;
			volt_high_q  <= '0;
			curr_limit_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				rtg_pkg::CFG_MODE:       mode_q       <= cfg_data[rtg_pkg::ModeW-1:0];
				rtg_pkg::CFG_LEAK_SRC:   leak_src_q   <= cfg_data[1:0];
				rtg_pkg::CFG_LEVEL_SEL:  level_sel_q  <= cfg_data[1:0];
				rtg_pkg::CFG_TEMP_LOW:   temp_low_q   <= cfg_data[rtg_pkg::TempW-1:0];
				rtg_pkg::CFG_TEMP_HIGH:  temp_high_q  <= cfg_data[rtg_pkg::TempW-1:0];
				rtg_pkg::CFG_VOLT_LOW:   volt_low_q   <= cfg_data[rtg_pkg::VoltW-1:0];
				rtg_pkg::CFG_VOLT_HIGH:  volt_high_q  <= cfg_data[rtg_pkg::VoltW-1:0];
				default:                 curr_limit_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			guard_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				relay_q     <= relay_n;
				guard_q     <= guard_n;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= {guard_n, clr_n, rep_n, relay_n};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(rtg_pkg::OutDataW-4){1'b0}}, out_data_q};

`ifndef SYNTH
	a_state_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[0] == relay_q && out_data_q[3] == guard_q))
		else $error("held beat disagrees with relay or guard state");

	a_clear_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[2] |-> !out_data_q[3])
		else $error("guard cleared but still armed");

	a_arm_sets_guard: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && s_axis_tuser == rtg_pkg::REQ_ARM |=> guard_q)
		else $error("arm command did not arm the guard");

	a_cmd_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && s_axis_tuser != rtg_pkg::REQ_TICK |=> out_data_q[2:1] == 2'b00)
		else $error("non-tick beat raised a flag");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with an empty output register");
`endif

endmodule
